// ----- rtl/core/button_click_classifier_macros.svh -----
// assertion macros used by the button click classifier top level
`ifndef BUTTON_CLICK_CLASSIFIER_MACROS_SVH
`define BUTTON_CLICK_CLASSIFIER_MACROS_SVH

// same-cycle implication, checked at every rising edge outside reset
`define BCC_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bcc same-cycle check failed");

// next-cycle implication, checked at every rising edge outside reset
`define BCC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bcc next-cycle check failed");

`endif

// ----- rtl/core/bcc_pkg.sv -----
// package with shared types and constants of the button click classifier
package bcc_pkg;

   // default width of stored timestamps
   localparam int unsigned TimeBitsDefault = 32;

   // field widths
   localparam int unsigned NowBits = 32;
   localparam int unsigned CfgBits = 16;
   localparam int unsigned CsrIndexBits = 2;

   // stream data widths, padded to whole bytes
   localparam int unsigned ReqDataBits = 40;
   localparam int unsigned RspDataBits = 8;

   // register reset values
   localparam logic [CfgBits-1:0] LongPressReset = 16'd1250;
   localparam logic [CfgBits-1:0] GapMaxReset = 16'd250;
   localparam logic [CfgBits-1:0] GapMinReset = 16'd50;

   // register indexes
   typedef enum logic [CsrIndexBits-1:0] {
      CSR_LONG_PRESS = 2'd0,
      CSR_GAP_MAX = 2'd1,
      CSR_GAP_MIN = 2'd2
   } csr_index_type;

   // limits used by the decision logic
   typedef struct packed {
      logic [CfgBits-1:0] long_press_ms;
      logic [CfgBits-1:0] double_gap_max_ms;
      logic [CfgBits-1:0] double_gap_min_ms;
   } cfg_type;

   // one result item
   typedef struct packed {
      logic long_press;
      logic double_click;
      logic single_click;
   } flags_type;

endpackage

// ----- rtl/core/bcc_decide.sv -----
// click state and per-item decision logic of the button click classifier
module bcc_decide
   import bcc_pkg::*;
#(
   parameter int unsigned TIME_BITS = TimeBitsDefault
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic                 sample_first,
   input  logic                 sample_second,
   input  logic [TIME_BITS-1:0] now_ms,
   input  cfg_type              cfg,
   output flags_type            flags,
   output logic                 stable_level
);

   logic                 stable_level_ff, stable_level_in;
   logic [TIME_BITS-1:0] press_start_ff, press_start_in;
   logic [TIME_BITS-1:0] last_click_ff, last_click_in;
   logic                 long_reported_ff, long_reported_in;

   logic                 agree;
   logic                 press_edge;
   logic                 release_edge;
   logic [TIME_BITS-1:0] press_len;
   logic [TIME_BITS-1:0] click_gap;
   logic [TIME_BITS-1:0] long_lim;
   logic [TIME_BITS-1:0] gap_max;
   logic [TIME_BITS-1:0] gap_min;
   logic                 short_press;
   logic                 gap_hit;

   // level agreement and edges against the stored level
   assign agree = (sample_first == sample_second);
   assign press_edge = agree && !sample_first && stable_level_ff;
   assign release_edge = agree && sample_first && !stable_level_ff;

   // modular time differences and widened limits
   assign press_len = now_ms - press_start_ff;
   assign click_gap = now_ms - last_click_ff;
   assign long_lim = TIME_BITS'(cfg.long_press_ms);
   assign gap_max = TIME_BITS'(cfg.double_gap_max_ms);
   assign gap_min = TIME_BITS'(cfg.double_gap_min_ms);
   assign short_press = (press_len < long_lim);
   assign gap_hit = (click_gap <= gap_max) && (click_gap > gap_min);

   // result flags
   always_comb begin
      flags.double_click = release_edge && short_press && gap_hit;
      flags.single_click = release_edge && short_press && !gap_hit;
      // held press: no long report can fire on the press edge itself
      flags.long_press = agree && !sample_first && !stable_level_ff
                         && !long_reported_ff && (press_len > long_lim);
   end

   // next state
   always_comb begin
      stable_level_in = stable_level_ff;
      press_start_in = press_start_ff;
      last_click_in = last_click_ff;
      long_reported_in = long_reported_ff;
      if (step && agree) begin
         stable_level_in = sample_first;
         if (press_edge) begin
            press_start_in = now_ms;
         end
         if (release_edge) begin
            long_reported_in = 1'b0;
            if (short_press) begin
               last_click_in = now_ms;
            end
         end
         if (flags.long_press) begin
            long_reported_in = 1'b1;
         end
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         stable_level_ff <= 1'b1;
         press_start_ff <= '0;
         last_click_ff <= '0;
         long_reported_ff <= 1'b0;
      end else begin
         stable_level_ff <= stable_level_in;
         press_start_ff <= press_start_in;
         last_click_ff <= last_click_in;
         long_reported_ff <= long_reported_in;
      end
   end

   assign stable_level = stable_level_ff;

endmodule

// ----- rtl/core/button_click_classifier.sv -----
// top level of the button click classifier: stream ports, registers, stages
// an accepted transfer passes from the input register to the result register and out on rsp
// throughput: one item per cycle; the input register and the result
//   register form a two-stage pipeline that stalls only on rsp_tready
// reset: synchronous, active high; limits return to 1250/250/50, the
//   button reads as released and both pipeline stages empty
`include "button_click_classifier_macros.svh"

module button_click_classifier
   import bcc_pkg::*;
#(
   parameter int unsigned TIME_BITS = TimeBitsDefault
) (
   input  logic                    clock,
   input  logic                    reset,
   // input stream
   input  logic                    req_tvalid,
   output logic                    req_tready,
   // [0] sample_first, [1] sample_second, [33:2] now_ms, [39:34] zero
   input  logic [ReqDataBits-1:0]  req_tdata,
   // result stream
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // [0] single_click, [1] double_click, [2] long_press, [7:3] zero
   output logic [RspDataBits-1:0]  rsp_tdata,
   // register writes
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CsrIndexBits-1:0] csr_index,
   input  logic [CfgBits-1:0]      csr_data
);

   cfg_type cfg_ff, cfg_in;

   logic                 in_valid_ff, in_valid_in;
   logic                 in_first_ff, in_second_ff;
   logic [NowBits-1:0]   in_now_ff;
   logic                 out_valid_ff, out_valid_in;
   flags_type            out_flags_ff;

   logic                 out_en;
   logic                 in_en;
   logic                 fire;
   logic [63:0]          now_wide;
   logic [TIME_BITS-1:0] now_t;
   flags_type            flags;
   logic                 stable_level;

   // register writes, always taken
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_LONG_PRESS: cfg_in.long_press_ms = csr_data;
            CSR_GAP_MAX:    cfg_in.double_gap_max_ms = csr_data;
            CSR_GAP_MIN:    cfg_in.double_gap_min_ms = csr_data;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.long_press_ms <= LongPressReset;
         cfg_ff.double_gap_max_ms <= GapMaxReset;
         cfg_ff.double_gap_min_ms <= GapMinReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // pipeline advance
   assign out_en = !out_valid_ff || rsp_tready;
   assign fire = in_valid_ff && out_en;
   assign in_en = !in_valid_ff || out_en;
   assign req_tready = in_en;

   assign in_valid_in = in_en ? req_tvalid : in_valid_ff;
   assign out_valid_in = out_en ? in_valid_ff : out_valid_ff;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && in_en) begin
         in_first_ff <= req_tdata[0];
         in_second_ff <= req_tdata[1];
         in_now_ff <= req_tdata[NowBits+1:2];
      end
   end

   // timestamp reduced or widened to the stored width
   assign now_wide = {32'd0, in_now_ff};
   assign now_t = now_wide[TIME_BITS-1:0];

   bcc_decide #(
      .TIME_BITS(TIME_BITS)
   ) u_decide (
      .clock        (clock),
      .reset        (reset),
      .step         (fire),
      .sample_first (in_first_ff),
      .sample_second(in_second_ff),
      .now_ms       (now_t),
      .cfg          (cfg_ff),
      .flags        (flags),
      .stable_level (stable_level)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_flags_ff <= flags;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = {5'd0, out_flags_ff.long_press, out_flags_ff.double_click,
                       out_flags_ff.single_click};

   // checks
   `BCC_ASSERT_SAME(a_one_report, clock, reset, rsp_tvalid, $onehot0(rsp_tdata[2:0]))
   `BCC_ASSERT_NEXT(a_fire_shows, clock, reset, fire, rsp_tvalid)
   `BCC_ASSERT_NEXT(a_long_held, clock, reset, fire && flags.long_press, !stable_level)
   `BCC_ASSERT_SAME(a_double_bounds, clock, reset, fire && flags.double_click,
                    cfg_ff.double_gap_max_ms > cfg_ff.double_gap_min_ms)

endmodule

// ----- bench/tb_top.sv -----
// self-checking testbench for the button click classifier stream block
`timescale 1ns / 1ps

module tb_top;
   import bcc_pkg::*;

   localparam int CycleLimit = 1_000_000;
   localparam int PrintLimit = 40;

   // dut ports, all inputs known from time zero
   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [ReqDataBits-1:0]  req_tdata = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RspDataBits-1:0]  rsp_tdata;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CsrIndexBits-1:0] csr_index = '0;
   logic [CfgBits-1:0]      csr_data = '0;

   // button model state and its limits
   cfg_type             limits_q;
   logic                level_q;
   logic [NowBits-1:0]  press_start_q;
   logic [NowBits-1:0]  last_click_q;
   logic                long_done_q;

   // classifier outcomes still in flight
   flags_type pending_flags[$];

   // run bookkeeping
   int  mismatch_count = 0;
   int  result_count = 0;
   int  sample_count = 0;
   int  agree_count = 0;
   int  write_count = 0;
   int  single_count = 0;
   int  double_count = 0;
   int  long_count = 0;
   int  cycle_count = 0;
   int  rsp_hold_cycles = 0;
   bit  idle_enable = 1'b1;

   // stimulus shaping copies of the limits
   logic [NowBits-1:0] long_lim = {16'b0, LongPressReset};
   logic [NowBits-1:0] gap_max_lim = {16'b0, GapMaxReset};
   logic [NowBits-1:0] gap_min_lim = {16'b0, GapMinReset};
   logic [NowBits-1:0] last_release = '0;

   button_click_classifier DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #6 clock = ~clock;

   // run length guard
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("button_click_classifier test failed");
         $finish;
      end
   end

   // gap length: mostly short, now and then long
   function automatic int gap_len();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 80) return $urandom_range(1, 3);
      else if (pick < 97) return $urandom_range(4, 12);
      else return $urandom_range(20, 60);
   endfunction

   // classify one sample pair and advance the button state
   function automatic flags_type classify_sample(input logic pin_first, input logic pin_second,
                                                 input logic [NowBits-1:0] now);
      flags_type f;
      logic [NowBits-1:0] held;
      logic [NowBits-1:0] gap;
      f = '0;
      if (pin_first == pin_second) begin
         if (pin_first != level_q) begin
            if (!pin_first) begin
               press_start_q = now;
            end else begin
               held = now - press_start_q;
               if (held < {16'b0, limits_q.long_press_ms}) begin
                  gap = now - last_click_q;
                  if (gap <= {16'b0, limits_q.double_gap_max_ms} &&
                      gap > {16'b0, limits_q.double_gap_min_ms})
                     f.double_click = 1'b1;
                  else
                     f.single_click = 1'b1;
                  last_click_q = now;
               end
               long_done_q = 1'b0;
            end
         end
         // long press fires once while still held
         if (!pin_first && !long_done_q) begin
            held = now - press_start_q;
            if (held > {16'b0, limits_q.long_press_ms}) begin
               f.long_press = 1'b1;
               long_done_q = 1'b1;
            end
         end
         level_q = pin_first;
      end
      return f;
   endfunction

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatch_count++;
      if (mismatch_count <= PrintLimit)
         $display("mismatch on result %0d, %s: got %0h, expected %0h",
                  result_count, field, got, want);
   endtask

   // result check, register tracking and prediction, all sampled at the edge
   always @(posedge clock) begin : result_check
      flags_type want;
      if (reset) begin
         limits_q.long_press_ms = LongPressReset;
         limits_q.double_gap_max_ms = GapMaxReset;
         limits_q.double_gap_min_ms = GapMinReset;
         level_q = 1'b1;
         press_start_q = '0;
         last_click_q = '0;
         long_done_q = 1'b0;
      end else begin
         // result transfer against the oldest outcome
         if (rsp_tvalid && rsp_tready) begin
            if (pending_flags.size() == 0) begin
               report_mismatch("unexpected result", 32'(rsp_tdata), '0);
            end else begin
               want = pending_flags.pop_front();
               if (rsp_tdata[0] !== want.single_click)
                  report_mismatch("single_click", 32'(rsp_tdata[0]),
                                  32'(want.single_click));
               if (rsp_tdata[1] !== want.double_click)
                  report_mismatch("double_click", 32'(rsp_tdata[1]),
                                  32'(want.double_click));
               if (rsp_tdata[2] !== want.long_press)
                  report_mismatch("long_press", 32'(rsp_tdata[2]),
                                  32'(want.long_press));
               if (rsp_tdata[RspDataBits-1:3] !== '0)
                  report_mismatch("padding", 32'(rsp_tdata[RspDataBits-1:3]), '0);
            end
            result_count++;
         end
         // register write transfer
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_LONG_PRESS: limits_q.long_press_ms = csr_data;
               CSR_GAP_MAX:    limits_q.double_gap_max_ms = csr_data;
               CSR_GAP_MIN:    limits_q.double_gap_min_ms = csr_data;
               default:        ;
            endcase
         end
         // input transfer
         if (req_tvalid && req_tready) begin
            want = classify_sample(req_tdata[0], req_tdata[1], req_tdata[NowBits+1:2]);
            single_count += want.single_click;
            double_count += want.double_click;
            long_count += want.long_press;
            pending_flags.push_back(want);
         end
      end
   end

   // receiver: random stalls, plus long hold-off on request
   initial begin
      forever begin
         if (rsp_hold_cycles > 0) begin
            rsp_tready <= 1'b0;
            repeat (rsp_hold_cycles) @(posedge clock);
            rsp_hold_cycles = 0;
         end else if (idle_enable && $urandom_range(0, 99) < 25) begin
            rsp_tready <= 1'b0;
            repeat (gap_len()) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
   end

   // one sample pair, valid stays high when the next one follows at once
   task automatic send_sample(input logic pin_first, input logic pin_second,
                              input logic [NowBits-1:0] now);
      req_tvalid <= 1'b1;
      req_tdata <= {{(ReqDataBits-NowBits-2){1'b0}}, now, pin_second, pin_first};
      do @(posedge clock); while (!req_tready);
      sample_count++;
      if (pin_first == pin_second) agree_count++;
      if (idle_enable && $urandom_range(0, 99) < 30) begin
         req_tvalid <= 1'b0;
         repeat (gap_len()) @(posedge clock);
      end
   endtask

   // sender pause until every outcome has been seen
   task automatic wait_results_drained();
      req_tvalid <= 1'b0;
      while (pending_flags.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input logic [CfgBits-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      write_count++;
   endtask

   // new limits, only with the block idle
   task automatic program_limits(input logic [CfgBits-1:0] long_ms,
                                 input logic [CfgBits-1:0] gap_max_ms,
                                 input logic [CfgBits-1:0] gap_min_ms);
      wait_results_drained();
      write_register(CSR_LONG_PRESS, long_ms);
      write_register(CSR_GAP_MAX, gap_max_ms);
      write_register(CSR_GAP_MIN, gap_min_ms);
      long_lim = {16'b0, long_ms};
      gap_max_lim = {16'b0, gap_max_ms};
      gap_min_lim = {16'b0, gap_min_ms};
   endtask

   // press/release sequences with durations and gaps near the limits
   task automatic run_click_bursts(input int count);
      int target;
      int holds;
      logic bounce;
      logic [NowBits-1:0] dur;
      logic [NowBits-1:0] gap;
      logic [NowBits-1:0] press_at;
      logic [NowBits-1:0] release_at;
      logic [NowBits-1:0] hold_at;
      target = sample_count + count;
      while (sample_count < target) begin
         if ($urandom_range(0, 9) == 0) begin
            // noise: any pair, any time
            send_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom());
         end else begin
            case ($urandom_range(0, 9))
               0:       dur = long_lim - 1;
               1:       dur = long_lim;
               2:       dur = long_lim + 1;
               3:       dur = '0;
               4, 5:    dur = long_lim + $urandom_range(2, 4000);
               default: dur = $urandom_range(0, long_lim);
            endcase
            case ($urandom_range(0, 11))
               0:       gap = gap_min_lim - 1;
               1:       gap = gap_min_lim;
               2:       gap = gap_min_lim + 1;
               3:       gap = gap_max_lim - 1;
               4:       gap = gap_max_lim;
               5:       gap = gap_max_lim + 1;
               6:       gap = $urandom();
               default: gap = $urandom_range(0, gap_max_lim + 100);
            endcase
            release_at = last_release + gap;
            press_at = release_at - dur;
            bounce = ($urandom_range(0, 3) == 0);
            if (bounce) send_sample(1'b0, 1'b1, press_at);
            send_sample(1'b0, 1'b0, press_at);
            // samples while held, some right at the long limit
            holds = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
            repeat (holds) begin
               case ($urandom_range(0, 2))
                  0:       hold_at = press_at + long_lim;
                  1:       hold_at = press_at + long_lim + 1;
                  default: hold_at = press_at + $urandom_range(0, dur);
               endcase
               send_sample(1'b0, 1'b0, hold_at);
            end
            if (bounce) send_sample(1'b1, 1'b0, release_at);
            send_sample(1'b1, 1'b1, release_at);
            if ($urandom_range(0, 3) == 0)
               send_sample(1'b1, 1'b1, release_at + $urandom_range(1, 1000));
            last_release = release_at;
         end
      end
   endtask

   // hand-picked cases at the reset limits 1250/250/50
   task automatic test_directed_cases();
      // disagreeing samples, then an idle released pair
      send_sample(1'b0, 1'b1, 32'd0);
      send_sample(1'b1, 1'b0, 32'd5);
      send_sample(1'b1, 1'b1, 32'd10);
      // double clicks right after reset, gap 200 from time zero
      send_sample(1'b0, 1'b0, 32'd100);
      send_sample(1'b1, 1'b1, 32'd200);
      send_sample(1'b0, 1'b0, 32'd300);
      send_sample(1'b1, 1'b1, 32'd400);
      // gap too wide: single
      send_sample(1'b0, 1'b0, 32'd1000);
      send_sample(1'b1, 1'b1, 32'd1050);
      // gap exactly at the lower bound: single
      send_sample(1'b0, 1'b0, 32'd1060);
      send_sample(1'b1, 1'b1, 32'd1100);
      // gap exactly at the upper bound: double
      send_sample(1'b0, 1'b0, 32'd1200);
      send_sample(1'b1, 1'b1, 32'd1350);
      // release exactly at the long limit: nothing
      send_sample(1'b0, 1'b0, 32'd2000);
      send_sample(1'b1, 1'b1, 32'd3250);
      // held press: at limit nothing, just past it one long press, then silent
      send_sample(1'b0, 1'b0, 32'd4000);
      send_sample(1'b0, 1'b0, 32'd5250);
      send_sample(1'b0, 1'b0, 32'd5251);
      send_sample(1'b0, 1'b0, 32'd6000);
      send_sample(1'b1, 1'b1, 32'd6001);
      // press at the top of the time range, release after the wrap
      send_sample(1'b0, 1'b0, 32'hFFFF_FFFF);
      send_sample(1'b1, 1'b1, 32'h0000_0010);
      // release stamped earlier than the press: huge duration
      send_sample(1'b0, 1'b0, 32'h0000_0040);
      send_sample(1'b1, 1'b1, 32'h0000_0000);
   endtask

   // lower gap bound at or above the upper bound: never a double click
   task automatic test_crossed_gap_bounds();
      logic [NowBits-1:0] t;
      program_limits(LongPressReset, 16'd100, 16'd100);
      t = 32'd50000;
      send_sample(1'b0, 1'b0, t);
      send_sample(1'b1, 1'b1, t + 10);
      send_sample(1'b0, 1'b0, t + 40);
      send_sample(1'b1, 1'b1, t + 110);
      program_limits(LongPressReset, 16'd100, 16'd200);
      t = 32'd60000;
      send_sample(1'b0, 1'b0, t);
      send_sample(1'b1, 1'b1, t + 10);
      send_sample(1'b0, 1'b0, t + 100);
      send_sample(1'b1, 1'b1, t + 160);
      last_release = t + 160;
      run_click_bursts(60);
   endtask

   // limits at their extremes and in between
   task automatic test_limit_extremes();
      program_limits(16'd0, 16'd0, 16'd0);
      run_click_bursts(90);
      program_limits(16'hFFFF, 16'hFFFF, 16'hFFFF);
      run_click_bursts(90);
      program_limits(16'hFFFF, 16'hFFFF, 16'd0);
      run_click_bursts(90);
      program_limits(16'd0, 16'hFFFF, 16'd0);
      run_click_bursts(90);
      program_limits(16'd1, 16'd2, 16'd1);
      run_click_bursts(90);
      program_limits(16'($urandom()), 16'($urandom()), 16'($urandom()));
      run_click_bursts(90);
      program_limits(LongPressReset, GapMaxReset, GapMinReset);
      run_click_bursts(90);
   endtask

   // receiver holds off while the sender streams: the block must stall its input
   task automatic test_output_backpressure();
      wait_results_drained();
      idle_enable = 1'b0;
      rsp_hold_cycles = 300;
      run_click_bursts(60);
      wait_results_drained();
      idle_enable = 1'b1;
   endtask

   // long random run with changing limits and idling patterns
   task automatic test_random_traffic();
      for (int chunk = 0; chunk < 8; chunk++) begin
         if (chunk % 2 == 1) begin
            if ($urandom_range(0, 3) == 0)
               program_limits(16'($urandom()), 16'($urandom()), 16'($urandom()));
            else
               program_limits(16'($urandom_range(0, 3000)), 16'($urandom_range(0, 600)),
                              16'($urandom_range(0, 300)));
         end
         // some chunks run with no idling at all
         idle_enable = ($urandom_range(0, 3) != 0);
         run_click_bursts(50);
         if (chunk == 3) wait_results_drained();
         run_click_bursts(50);
      end
      idle_enable = 1'b1;
   endtask

   // test sequence
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_crossed_gap_bounds();
      test_limit_extremes();
      test_output_backpressure();
      test_random_traffic();
      wait_results_drained();
      repeat (8) @(posedge clock);
      $display("sent %0d sample pairs (%0d agreeing), checked %0d results, %0d register writes",
               sample_count, agree_count, result_count, write_count);
      $display("outcomes seen: %0d single, %0d double, %0d long press",
               single_count, double_count, long_count);
      if (mismatch_count == 0) begin
         $display("button_click_classifier test passed");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("button_click_classifier test failed");
      end
      $finish;
   end

endmodule
